>>> rtl/owbm_pkg.sv
// Shared types, codes and constants for the one-wire bus master core.
package owbm_pkg;

  // Widths fixed by the register map and the beat fields
  localparam int CFG_W        = 10;
  localparam int SLOT_W       = 4;
  localparam int CFG_IDX_W    = 3;
  localparam int BYTE_W       = 8;
  localparam int BITCNT_W     = 4;

  // Default bus timer width and the depth of the front-to-back queue
  localparam int TIMER_BITS_DEF = 10;
  localparam int QUEUE_DEPTH    = 2;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_WAIT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RESET_TAIL    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WRITE_SLOT    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_READ_TAIL     = 3'd6;

  // Power-on timing, in microsecond ticks
  localparam logic [CFG_W-1:0]  RESET_LOW_INIT     = 10'd480;
  localparam logic [CFG_W-1:0]  PRESENCE_WAIT_INIT = 10'd70;
  localparam logic [CFG_W-1:0]  RESET_TAIL_INIT    = 10'd410;
  localparam logic [SLOT_W-1:0] SLOT_LOW_INIT      = 4'd1;
  localparam logic [CFG_W-1:0]  WRITE_SLOT_INIT    = 10'd60;
  localparam logic [CFG_W-1:0]  READ_SAMPLE_INIT   = 10'd14;
  localparam logic [CFG_W-1:0]  READ_TAIL_INIT     = 10'd45;

  // Bus operations, coded as on the func field
  typedef enum logic [2:0] {
    OP_RESET = 3'd0,
    OP_WBYTE = 3'd1,
    OP_RBYTE = 3'd2,
    OP_WBIT  = 3'd3,
    OP_RBIT  = 3'd4
  } op_t;

  // Sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE       = 4'd0,
    PH_RST_LOW    = 4'd1,
    PH_RST_WAIT   = 4'd2,
    PH_RST_SAMPLE = 4'd3,
    PH_RST_TAIL   = 4'd4,
    PH_SLOT_LOW   = 4'd5,
    PH_WR_HOLD    = 4'd6,
    PH_RD_WAIT    = 4'd7,
    PH_RD_SAMPLE  = 4'd8,
    PH_RD_TAIL    = 4'd9
  } phase_t;

  // Input beat: one tick
  typedef struct packed {
    logic              cmd_valid;
    logic [2:0]        func;
    logic [BYTE_W-1:0] write_value;
    logic              line_level;
  } owbm_in_t;

  // Result beat: one tick
  typedef struct packed {
    logic              pull_low;
    logic              busy_res;
    logic              done_res;
    logic [BYTE_W-1:0] read_result;
    logic              presence;
    logic              rejected;
  } owbm_out_t;

  // Classified tick, as queued between front and back
  typedef struct packed {
    logic              cmd_valid;
    logic              start;
    op_t               op;
    logic [BYTE_W-1:0] write_value;
    logic              line_level;
  } owbm_item_t;

endpackage

>>> rtl/owbm_front.sv
// Front end: takes tick beats and decodes the command they carry.
module owbm_front (
  input  logic                in_valid,
  output logic                in_ready,
  input  owbm_pkg::owbm_in_t  in_data,
  input  logic                q_full,
  output logic                q_push,
  output owbm_pkg::owbm_item_t q_item
);
  import owbm_pkg::*;

  op_t op_dec;

  // Map func onto an operation; codes above read bit are not commands
  always_comb begin
    unique case (in_data.func)
      OP_RESET: op_dec = OP_RESET;
      OP_WBYTE: op_dec = OP_WBYTE;
      OP_RBYTE: op_dec = OP_RBYTE;
      OP_WBIT:  op_dec = OP_WBIT;
      OP_RBIT:  op_dec = OP_RBIT;
      default:  op_dec = OP_RESET;
    endcase
  end

  // Handshake towards the queue
  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;

  // Classified item
  always_comb begin
    q_item.cmd_valid   = in_data.cmd_valid;
    q_item.start       = in_data.cmd_valid && (in_data.func <= OP_RBIT);
    q_item.op          = op_dec;
    q_item.write_value = in_data.write_value;
    q_item.line_level  = in_data.line_level;
  end

endmodule

>>> rtl/owbm_queue.sv
// Short queue of classified ticks between the front end and the sequencer.
module owbm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  owbm_pkg::owbm_item_t push_item,
  output logic                 full,
  input  logic                 pop,
  output logic                 q_valid,
  output owbm_pkg::owbm_item_t pop_item
);
  import owbm_pkg::*;

  localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CW-1:0] DEPTH_C = CW'(QUEUE_DEPTH);

  owbm_item_t      slots [QUEUE_DEPTH];
  logic [AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  assign full     = (count_r == DEPTH_C);
  assign q_valid  = (count_r != '0);
  assign pop_item = slots[rd_ptr_r];

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + AW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + AW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Storage, no reset needed
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr_r] <= push_item;
    end
  end

  // Fill count stays in range and steps up on a push; no pop while empty
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C)
    else $error("queue fill count beyond depth");

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> q_valid)
    else $error("queue popped while empty");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CW'(1)))
    else $error("queue fill count missed a push");

endmodule

>>> rtl/owbm_engine.sv
// Back end: timing registers, bus sequencer and the result register.
module owbm_engine #(
  parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [owbm_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]           cfg_wdata,
  input  logic                                 q_valid,
  input  owbm_pkg::owbm_item_t                 item,
  output logic                                 pop,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output owbm_pkg::owbm_out_t                  out_data
);
  import owbm_pkg::*;

  // Timer loads: v - 1, zero counts as one, saturated at the timer width
  localparam int CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [CW-1:0] TMAX = CW'((64'd1 << TIMER_BITS) - 64'd1);

  function automatic logic [TIMER_BITS-1:0] load_timer(input logic [CFG_W-1:0] v);
    logic [CW-1:0] t;
    t = (v == '0) ? '0 : CW'(v - CFG_W'(1));
    if (t > TMAX) begin
      t = TMAX;
    end
    return TIMER_BITS'(t);
  endfunction

  // Timing registers
  logic [CFG_W-1:0]  rst_low_r, pres_wait_r, rst_tail_r;
  logic [SLOT_W-1:0] slot_low_r;
  logic [CFG_W-1:0]  wr_slot_r, rd_sample_r, rd_tail_r;

  // Sequencer state
  phase_t                phase_r, ph_e, ph_nxt;
  op_t                   op_r, op_e;
  logic [TIMER_BITS-1:0] timer_r, tm_e, timer_nxt, tm_dec;
  logic [BITCNT_W-1:0]   bits_r, bits_e, bits_nxt, bits_dec;
  logic [BYTE_W-1:0]     shift_r, shift_e, shift_nxt;
  logic                  pres_r, pres_nxt;
  logic                  expired, slot_end, finish;

  // Result register
  logic                  out_valid_r;
  owbm_out_t             out_r, out_nxt;

  assign pop       = q_valid && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rst_low_r   <= RESET_LOW_INIT;
      pres_wait_r <= PRESENCE_WAIT_INIT;
      rst_tail_r  <= RESET_TAIL_INIT;
      slot_low_r  <= SLOT_LOW_INIT;
      wr_slot_r   <= WRITE_SLOT_INIT;
      rd_sample_r <= READ_SAMPLE_INIT;
      rd_tail_r   <= READ_TAIL_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_RESET_LOW:     rst_low_r   <= cfg_wdata;
        REG_PRESENCE_WAIT: pres_wait_r <= cfg_wdata;
        REG_RESET_TAIL:    rst_tail_r  <= cfg_wdata;
        REG_SLOT_LOW:      slot_low_r  <= cfg_wdata[SLOT_W-1:0];
        REG_WRITE_SLOT:    wr_slot_r   <= cfg_wdata;
        REG_READ_SAMPLE:   rd_sample_r <= cfg_wdata;
        REG_READ_TAIL:     rd_tail_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Command start: an idle sequencer takes the command and runs it this tick
  always_comb begin
    ph_e    = phase_r;
    op_e    = op_r;
    tm_e    = timer_r;
    bits_e  = bits_r;
    shift_e = shift_r;
    if (phase_r == PH_IDLE && item.start) begin
      op_e = item.op;
      if (item.op == OP_RESET) begin
        ph_e = PH_RST_LOW;
        tm_e = load_timer(rst_low_r);
      end else begin
        bits_e = (item.op == OP_WBYTE || item.op == OP_RBYTE) ?
                 BITCNT_W'(8) : BITCNT_W'(1);
        if (item.op == OP_WBYTE) begin
          shift_e = item.write_value;
        end else if (item.op == OP_WBIT) begin
          shift_e = {{(BYTE_W-1){1'b0}}, item.write_value[0]};
        end else begin
          shift_e = '0;
        end
        ph_e = PH_SLOT_LOW;
        tm_e = load_timer(CFG_W'(slot_low_r));
      end
    end
  end

  assign expired  = (tm_e == '0);
  assign tm_dec   = tm_e - TIMER_BITS'(1);
  assign bits_dec = bits_e - BITCNT_W'(1);

  // Next state
  always_comb begin
    ph_nxt    = ph_e;
    timer_nxt = tm_e;
    bits_nxt  = bits_e;
    shift_nxt = shift_e;
    pres_nxt  = pres_r;
    slot_end  = 1'b0;
    finish    = 1'b0;
    unique case (ph_e)
      PH_IDLE: ;
      PH_RST_LOW: begin
        if (expired) begin
          ph_nxt    = PH_RST_WAIT;
          timer_nxt = load_timer(pres_wait_r);
        end else begin
          timer_nxt = tm_dec;
        end
      end
      PH_RST_WAIT: begin
        if (expired) ph_nxt = PH_RST_SAMPLE;
        else timer_nxt = tm_dec;
      end
      PH_RST_SAMPLE: begin
        pres_nxt = !item.line_level;
        if (rst_tail_r <= CFG_W'(1)) begin
          finish = 1'b1;
        end else begin
          ph_nxt    = PH_RST_TAIL;
          timer_nxt = load_timer(rst_tail_r - CFG_W'(1));
        end
      end
      PH_RST_TAIL: begin
        if (expired) finish = 1'b1;
        else timer_nxt = tm_dec;
      end
      PH_SLOT_LOW: begin
        if (expired) begin
          if (op_e == OP_WBYTE || op_e == OP_WBIT) begin
            ph_nxt    = PH_WR_HOLD;
            timer_nxt = load_timer(wr_slot_r);
          end else begin
            ph_nxt    = PH_RD_WAIT;
            timer_nxt = load_timer(rd_sample_r);
          end
        end else begin
          timer_nxt = tm_dec;
        end
      end
      PH_WR_HOLD: begin
        if (expired) begin
          shift_nxt = {1'b0, shift_e[BYTE_W-1:1]};
          slot_end  = 1'b1;
        end else begin
          timer_nxt = tm_dec;
        end
      end
      PH_RD_WAIT: begin
        if (expired) ph_nxt = PH_RD_SAMPLE;
        else timer_nxt = tm_dec;
      end
      PH_RD_SAMPLE: begin
        shift_nxt = {item.line_level, shift_e[BYTE_W-1:1]};
        if (rd_tail_r <= CFG_W'(1)) begin
          slot_end = 1'b1;
        end else begin
          ph_nxt    = PH_RD_TAIL;
          timer_nxt = load_timer(rd_tail_r - CFG_W'(1));
        end
      end
      PH_RD_TAIL: begin
        if (expired) slot_end = 1'b1;
        else timer_nxt = tm_dec;
      end
      default: ph_nxt = PH_IDLE;
    endcase

    // End of a bit slot: next slot or done
    if (slot_end) begin
      bits_nxt = bits_dec;
      if (bits_dec != '0) begin
        ph_nxt    = PH_SLOT_LOW;
        timer_nxt = load_timer(CFG_W'(slot_low_r));
      end else begin
        finish = 1'b1;
      end
    end
    if (finish) begin
      ph_nxt    = PH_IDLE;
      timer_nxt = '0;
    end
  end

  // Result beat
  always_comb begin
    out_nxt             = '0;
    out_nxt.presence    = pres_nxt;
    out_nxt.rejected    = item.cmd_valid && (phase_r != PH_IDLE);
    out_nxt.done_res    = finish;
    unique case (ph_e)
      PH_IDLE: ;
      PH_RST_LOW, PH_SLOT_LOW: begin
        out_nxt.busy_res = 1'b1;
        out_nxt.pull_low = 1'b1;
      end
      PH_WR_HOLD: begin
        out_nxt.busy_res = 1'b1;
        out_nxt.pull_low = !shift_e[0];
      end
      PH_RST_WAIT, PH_RST_SAMPLE, PH_RST_TAIL,
      PH_RD_WAIT, PH_RD_SAMPLE, PH_RD_TAIL: begin
        out_nxt.busy_res = 1'b1;
      end
      default: ;
    endcase
    if (finish && op_e == OP_RBYTE) begin
      out_nxt.read_result = shift_nxt;
    end else if (finish && op_e == OP_RBIT) begin
      out_nxt.read_result = {{(BYTE_W-1){1'b0}}, shift_nxt[BYTE_W-1]};
    end
  end

  // State and result registers advance once per popped tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_IDLE;
      op_r        <= OP_RESET;
      timer_r     <= '0;
      bits_r      <= '0;
      shift_r     <= '0;
      pres_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        phase_r <= ph_nxt;
        op_r    <= op_e;
        timer_r <= timer_nxt;
        bits_r  <= bits_nxt;
        shift_r <= shift_nxt;
        pres_r  <= pres_nxt;
      end
      if (pop) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_r <= out_nxt;
    end
  end

  // A command on a tick that began busy is always flagged
  a_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && item.cmd_valid && phase_r != PH_IDLE) |=> (out_valid_r && out_r.rejected))
    else $error("command during busy tick not rejected");

  // Completion only on a busy tick
  a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.done_res) |-> out_r.busy_res)
    else $error("done without busy");

  // Bit slot phases always have a slot outstanding
  a_bits_live: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_SLOT_LOW || phase_r == PH_WR_HOLD || phase_r == PH_RD_WAIT ||
     phase_r == PH_RD_SAMPLE || phase_r == PH_RD_TAIL) |-> (bits_r != '0))
    else $error("bit slot running with no bits left");

  // Idle sequencer holds a cleared timer
  a_idle_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (timer_r == '0))
    else $error("idle with timer running");

endmodule

>>> rtl/one_wire_bus_master_core.sv
// One-wire bus master: front end, tick queue and bus sequencer.
// Each input beat is one microsecond tick of the bus timebase carrying the
// sampled DQ level and an optional command (bus reset, write or read of a byte
// or a single bit); each tick yields exactly one result beat with the pull-low
// drive for that tick, busy, done, read data, presence and a rejected flag.
// One tick is taken per clock cycle while the queue has room. Each tick
// passes through the two-entry tick queue and the combinational sequencer
// step, which writes straight into the result register. A stall on the
// result side backs up into the queue and then input ready. Timing
// registers are written through the cfg_ port and apply from the next phase.
module one_wire_bus_master_core #(
  parameter int TIMER_BITS = owbm_pkg::TIMER_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [owbm_pkg::CFG_W-1:0]     cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  owbm_pkg::owbm_in_t             in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output owbm_pkg::owbm_out_t            out_data
);
  import owbm_pkg::*;

  logic       q_push, q_full, q_pop, q_valid;
  owbm_item_t push_item, pop_item;

  // Accept and classify ticks
  owbm_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (push_item)
  );

  // Decoupling queue
  owbm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (q_pop),
    .q_valid   (q_valid),
    .pop_item  (pop_item)
  );

  // Bus sequencer
  owbm_engine #(
    .TIMER_BITS (TIMER_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .q_valid   (q_valid),
    .item      (pop_item),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
